/* rtl/core/rtp_nal_fragment_packetizer_core_macros.svh */
// ----------------------------------------------------------------------------
// RTP NAL packetizer assertion macros
// Shared assertion wrappers for the packetizer core. Defining ASSERT_OFF
// compiles every check away.
// ----------------------------------------------------------------------------
`ifndef RTP_NAL_FRAGMENT_PACKETIZER_CORE_MACROS_SVH
`define RTP_NAL_FRAGMENT_PACKETIZER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Checked property, muted while reset is high.
`define RNFP_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds during reset.
`define RNFP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RNFP_ASSERT(name, clk, rst, prop, msg)
`define RNFP_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

/* rtl/core/rnfp_pkg.sv */
// ----------------------------------------------------------------------------
// RTP NAL packetizer package
// Field widths, header constants, fragment modes and the command word that
// travels from the front part to the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package rnfp_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMESTAMP_STEP = 1'd1;

  // Reset values of the registers.
  localparam logic [15:0] MAX_PAYLOAD_RESET    = 16'd1400;
  localparam logic [31:0] TIMESTAMP_STEP_RESET = 32'd3000;
  localparam logic [15:0] MIN_PAYLOAD          = 16'd16;

  // Fragment modes.
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_AVC    = 2'd1;
  localparam logic [1:0] MODE_HEVC   = 2'd2;
  localparam logic [1:0] MODE_OTHER  = 2'd3;

  // Start code lengths.
  localparam logic [2:0] SC_SHORT = 3'd3;
  localparam logic [2:0] SC_LONG  = 3'd4;
  localparam logic [2:0] POS_SC_SELECT = 3'd2;
  localparam logic [2:0] POS_SAT       = 3'd7;
  localparam logic [7:0] SC_LAST_BYTE  = 8'h01;

  // RTP header bytes.
  localparam logic [4:0] HDR_BYTES  = 5'd12;
  localparam logic [7:0] RTP_VER    = 8'h80;
  localparam logic [7:0] RTP_PT     = 8'h60;
  localparam logic [7:0] RTP_PT_MK  = 8'hE0;
  localparam logic [7:0] SSRC_B0    = 8'hEF;
  localparam logic [7:0] SSRC_B1    = 8'hBE;
  localparam logic [7:0] SSRC_B2    = 8'hAD;
  localparam logic [7:0] SSRC_B3    = 8'hDE;

  // Fragmentation header fields.
  localparam logic [7:0] FU_A_TYPE     = 8'd28;
  localparam logic [7:0] HEVC_FU_TYPE  = 8'd98;
  localparam logic [7:0] NRI_MASK      = 8'hE0;
  localparam logic [7:0] AVC_TYPE_MASK = 8'h1F;
  localparam logic [7:0] HEVC_KEEP     = 8'h81;
  localparam logic [7:0] FU_START      = 8'h80;
  localparam logic [7:0] FU_END        = 8'h40;
  localparam logic [4:0] AVC_NON_IDR   = 5'd1;
  localparam logic [4:0] AVC_IDR       = 5'd5;
  localparam logic [5:0] HEVC_TRAIL_R  = 6'd1;
  localparam logic [5:0] HEVC_IDR_W    = 6'd19;

  // One queued command: an optional RTP header, up to three extra header
  // bytes and an optional payload byte.
  typedef struct packed {
    logic            hdr;
    logic            marker;
    logic [15:0]     seq;
    logic [31:0]     ts;
    logic [1:0]      nx;
    logic [2:0][7:0] xb;
    logic            pay;
    logic [7:0]      pay_byte;
    logic            pend;
    logic            uend;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/rnfp_if.sv */
// ----------------------------------------------------------------------------
// RTP NAL packetizer channels
// Valid/ready channels for the input unit bytes and the packet bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rnfp_in_if import rnfp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_of_unit;
  logic [22:0] unit_length;

  modport source (output valid, data_byte, first_of_unit, unit_length, input ready);
  modport sink (input valid, data_byte, first_of_unit, unit_length, output ready);
endinterface

interface rnfp_out_if import rnfp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_end;
  logic       unit_end;

  modport source (output valid, out_byte, packet_end, unit_end, input ready);
  modport sink (input valid, out_byte, packet_end, unit_end, output ready);
endinterface

`default_nettype wire

/* rtl/core/rnfp_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// RTP NAL packetizer command queue
// Short first-in first-out queue of commands between the front part and
// the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rtp_nal_fragment_packetizer_core_macros.svh"

module rnfp_cmd_fifo import rnfp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t wr_cmd,
  input  wire logic pop,
  output cmd_t      rd_cmd,
  output logic      full,
  output logic      empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign rd_cmd = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage of the queued commands.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  `RNFP_ASSERT(a_push_has_room, clk, rst, push |-> !full, "command pushed into a full queue")
  `RNFP_ASSERT(a_pop_has_data, clk, rst, pop |-> !empty, "command popped from an empty queue")
  `RNFP_ASSERT(a_count_bound, clk, rst, count <= CW'(DEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

/* rtl/core/rnfp_front.sv */
// ----------------------------------------------------------------------------
// RTP NAL packetizer front part
// Accepts unit bytes, strips the start code, tracks unit and packet
// counters and turns every byte after the start code into one command.
// ----------------------------------------------------------------------------
`default_nettype none

module rnfp_front import rnfp_pkg::*; #(
  parameter int MAX_UNIT_BYTES    = 4194304,
  parameter int MAX_PAYLOAD_BYTES = 65532
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  rnfp_in_if.sink                   nal_in,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire logic                 full,
  output logic                      push,
  output cmd_t                      cmd
);

  localparam int UW = $clog2(MAX_UNIT_BYTES + 1);
  localparam int CW = (UW > 17) ? UW : 17;

  // Configuration registers.
  logic [15:0] max_payload;
  logic [31:0] timestamp_step;

  // Unit state.
  logic [15:0]   seq;
  logic [31:0]   ts;
  logic [UW-1:0] unit_left;
  logic [15:0]   pkt_left;
  logic [2:0]    scl;
  logic [1:0]    mode;
  logic [7:0]    nal_hdr;
  logic          first_pending;
  logic [2:0]    pos;
  logic [7:0]    hevc_second;
  logic [15:0]   limit;

  logic [15:0]   seq_next;
  logic [31:0]   ts_next;
  logic [UW-1:0] unit_left_next;
  logic [15:0]   pkt_left_next;
  logic [2:0]    scl_next;
  logic [1:0]    mode_next;
  logic [7:0]    nal_hdr_next;
  logic          first_pending_next;
  logic [2:0]    pos_next;
  logic [7:0]    hevc_second_next;
  logic [15:0]   limit_next;

  logic          acc;
  logic [7:0]    b;
  logic          unit_ok;
  logic          new_unit;
  logic [UW-1:0] len_sat;
  logic [15:0]   lim_clamp;
  logic [UW-1:0] eff_unit;
  logic [15:0]   eff_pkt;
  logic [2:0]    eff_pos;
  logic [2:0]    eff_scl;
  logic [1:0]    eff_mode;
  logic          eff_first_pending;
  logic [15:0]   eff_limit;
  logic [31:0]   eff_ts;
  logic [CW-1:0] rem_w;
  logic          rem_one;
  logic          fits;
  logic          last_chunk;
  logic [15:0]   chunk;
  logic [4:0]    avc_type;
  logic [5:0]    hevc_type;
  logic [15:0]   pkt_base;

  assign nal_in.ready = !full;
  assign acc          = nal_in.valid && nal_in.ready;
  assign b            = nal_in.data_byte;

  // Length checks and limit clamping for a new unit.
  assign unit_ok  = (nal_in.unit_length >= 23'd5);
  assign new_unit = nal_in.first_of_unit && unit_ok;
  assign len_sat  = (32'(nal_in.unit_length) > 32'(MAX_UNIT_BYTES)) ?
                    UW'(MAX_UNIT_BYTES) : UW'(nal_in.unit_length);
  assign lim_clamp = (max_payload < MIN_PAYLOAD) ? MIN_PAYLOAD :
                     (max_payload > 16'(MAX_PAYLOAD_BYTES)) ? 16'(MAX_PAYLOAD_BYTES) :
                     max_payload;

  // State as seen by this byte, after any unit restart.
  assign eff_unit = nal_in.first_of_unit ? (unit_ok ? len_sat : '0) : unit_left;
  assign eff_pkt  = nal_in.first_of_unit ? '0 : pkt_left;
  assign eff_pos  = new_unit ? '0 : pos;
  assign eff_scl  = new_unit ? SC_LONG : scl;
  assign eff_mode = new_unit ? MODE_SINGLE : mode;
  assign eff_first_pending = new_unit ? 1'b1 : first_pending;
  assign eff_limit = new_unit ? lim_clamp : limit;
  assign eff_ts    = new_unit ? ts + timestamp_step : ts;

  // Packet sizing against the latched limit.
  assign rem_w      = CW'(eff_unit);
  assign rem_one    = (eff_unit == UW'(1));
  assign fits       = (rem_w <= CW'(eff_limit) + CW'(eff_scl));
  assign last_chunk = (rem_w <= CW'(eff_limit));
  assign chunk      = last_chunk ? 16'(eff_unit) : eff_limit;
  assign avc_type   = b[4:0];
  assign hevc_type  = b[6:1];

  // Per-byte decision and command build.
  always_comb begin
    seq_next           = seq;
    ts_next            = ts;
    unit_left_next     = unit_left;
    pkt_left_next      = pkt_left;
    scl_next           = scl;
    mode_next          = mode;
    nal_hdr_next       = nal_hdr;
    first_pending_next = first_pending;
    pos_next           = pos;
    hevc_second_next   = hevc_second;
    limit_next         = limit;
    pkt_base           = eff_pkt;
    push               = 1'b0;
    cmd                = '0;
    cmd.seq            = seq;
    cmd.ts             = eff_ts;
    cmd.pay_byte       = b;
    cmd.uend           = rem_one;
    if (acc) begin
      ts_next            = eff_ts;
      unit_left_next     = eff_unit;
      pkt_left_next      = eff_pkt;
      scl_next           = eff_scl;
      mode_next          = eff_mode;
      first_pending_next = eff_first_pending;
      pos_next           = eff_pos;
      limit_next         = eff_limit;
      if (eff_unit != '0) begin
        unit_left_next = eff_unit - 1'b1;
        if (eff_pos < POS_SAT) begin
          pos_next = eff_pos + 1'b1;
        end
        if (eff_pos == POS_SC_SELECT) begin
          // Third start code byte tells a short code from a long one.
          scl_next = (b == SC_LAST_BYTE) ? SC_SHORT : SC_LONG;
        end else if (eff_pos == eff_scl) begin
          // NAL header byte: open the first packet of the unit.
          nal_hdr_next = b;
          push         = 1'b1;
          cmd.hdr      = 1'b1;
          seq_next     = seq + 1'b1;
          if (fits) begin
            mode_next          = MODE_SINGLE;
            first_pending_next = 1'b0;
            cmd.pay            = 1'b1;
            pkt_left_next      = 16'(eff_unit - 1'b1);
            cmd.pend           = rem_one;
          end else if (avc_type == AVC_NON_IDR || avc_type == AVC_IDR) begin
            mode_next          = MODE_AVC;
            first_pending_next = 1'b0;
            cmd.nx             = 2'd2;
            cmd.xb[0]          = (b & NRI_MASK) | FU_A_TYPE;
            cmd.xb[1]          = FU_START | {3'b000, avc_type};
            pkt_left_next      = eff_limit;
          end else if (hevc_type == HEVC_TRAIL_R || hevc_type == HEVC_IDR_W) begin
            mode_next     = MODE_HEVC;
            cmd.nx        = 2'd1;
            cmd.xb[0]     = (b & HEVC_KEEP) | HEVC_FU_TYPE;
            pkt_left_next = eff_limit;
          end else begin
            mode_next          = MODE_OTHER;
            first_pending_next = 1'b0;
            cmd.nx             = 2'd2;
            cmd.pay            = 1'b1;
            pkt_left_next      = eff_limit - 1'b1;
            cmd.pend           = (eff_limit == 16'd1);
          end
        end else if (eff_pos > eff_scl) begin
          if (eff_mode == MODE_HEVC && eff_first_pending) begin
            // Second HEVC header byte completes the first fragment header.
            first_pending_next = 1'b0;
            hevc_second_next   = b;
            push               = 1'b1;
            cmd.nx             = 2'd2;
            cmd.xb[0]          = b;
            cmd.xb[1]          = FU_START | {2'b00, nal_hdr[6:1]};
          end else begin
            push    = 1'b1;
            cmd.pay = 1'b1;
            if (eff_pkt == '0) begin
              // Open a follow-on packet.
              cmd.hdr    = 1'b1;
              cmd.marker = last_chunk;
              seq_next   = seq + 1'b1;
              pkt_base   = chunk;
              case (eff_mode)
                MODE_AVC: begin
                  cmd.nx    = 2'd2;
                  cmd.xb[0] = (nal_hdr & NRI_MASK) | FU_A_TYPE;
                  cmd.xb[1] = (nal_hdr & AVC_TYPE_MASK) | (last_chunk ? FU_END : 8'h00);
                end
                MODE_HEVC: begin
                  cmd.nx    = 2'd3;
                  cmd.xb[0] = (nal_hdr & HEVC_KEEP) | HEVC_FU_TYPE;
                  cmd.xb[1] = hevc_second;
                  cmd.xb[2] = {2'b00, nal_hdr[6:1]} | (last_chunk ? FU_END : 8'h00);
                end
                MODE_OTHER: begin
                  cmd.nx = 2'd2;
                end
                default: begin
                  cmd.nx = 2'd0;
                end
              endcase
            end
            pkt_left_next = (pkt_base != '0) ? pkt_base - 1'b1 : '0;
            cmd.pend      = (pkt_base <= 16'd1);
          end
        end
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload    <= MAX_PAYLOAD_RESET;
      timestamp_step <= TIMESTAMP_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_PAYLOAD:    max_payload    <= cfg_data[15:0];
        REG_TIMESTAMP_STEP: timestamp_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unit and packet state.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq           <= '0;
      ts            <= '0;
      unit_left     <= '0;
      pkt_left      <= '0;
      scl           <= SC_LONG;
      mode          <= MODE_SINGLE;
      nal_hdr       <= '0;
      first_pending <= 1'b1;
      pos           <= '0;
      hevc_second   <= '0;
      limit         <= '0;
    end else begin
      seq           <= seq_next;
      ts            <= ts_next;
      unit_left     <= unit_left_next;
      pkt_left      <= pkt_left_next;
      scl           <= scl_next;
      mode          <= mode_next;
      nal_hdr       <= nal_hdr_next;
      first_pending <= first_pending_next;
      pos           <= pos_next;
      hevc_second   <= hevc_second_next;
      limit         <= limit_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rnfp_back.sv */
// ----------------------------------------------------------------------------
// RTP NAL packetizer serializer
// Expands each queued command into its RTP header, fragmentation header
// and payload bytes, one word per cycle while the sink is ready, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rtp_nal_fragment_packetizer_core_macros.svh"

module rnfp_back import rnfp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t head,
  input  wire logic empty,
  output logic      pop,
  rnfp_out_if.source rtp_out
);

  cmd_t       cur;
  logic       cur_valid;
  logic [3:0] idx;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_pend;
  logic       out_uend;

  logic       advance;
  logic       emit;
  logic [4:0] hdr_n;
  logic [4:0] tot;
  logic [4:0] k;
  logic       is_last;
  logic [7:0] sel_byte;
  logic       sel_pend;
  logic       sel_uend;

  assign rtp_out.valid      = out_valid;
  assign rtp_out.out_byte   = out_byte;
  assign rtp_out.packet_end = out_pend;
  assign rtp_out.unit_end   = out_uend;

  // Word count of the current command and position tracking.
  assign advance = !out_valid || rtp_out.ready;
  assign emit    = cur_valid && advance;
  assign hdr_n   = cur.hdr ? HDR_BYTES : 5'd0;
  assign tot     = hdr_n + {3'b000, cur.nx} + {4'b0000, cur.pay};
  assign is_last = ({1'b0, idx} + 5'd1) == tot;
  assign k       = {1'b0, idx} - hdr_n;
  assign pop     = !empty && (!cur_valid || (emit && is_last));

  // Byte select for the current position.
  always_comb begin
    sel_byte = cur.pay_byte;
    sel_pend = 1'b0;
    sel_uend = 1'b0;
    if (cur.hdr && ({1'b0, idx} < HDR_BYTES)) begin
      case (idx)
        4'd0:    sel_byte = RTP_VER;
        4'd1:    sel_byte = cur.marker ? RTP_PT_MK : RTP_PT;
        4'd2:    sel_byte = cur.seq[15:8];
        4'd3:    sel_byte = cur.seq[7:0];
        4'd4:    sel_byte = cur.ts[31:24];
        4'd5:    sel_byte = cur.ts[23:16];
        4'd6:    sel_byte = cur.ts[15:8];
        4'd7:    sel_byte = cur.ts[7:0];
        4'd8:    sel_byte = SSRC_B0;
        4'd9:    sel_byte = SSRC_B1;
        4'd10:   sel_byte = SSRC_B2;
        default: sel_byte = SSRC_B3;
      endcase
    end else if (k < {3'b000, cur.nx}) begin
      sel_byte = cur.xb[k[1:0]];
    end else begin
      sel_pend = cur.pend;
      sel_uend = cur.uend;
    end
  end

  // Command register and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rtp_out.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (emit) begin
        idx <= idx + 1'b1;
        if (is_last) begin
          cur_valid <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (emit) begin
      out_byte <= sel_byte;
      out_pend <= sel_pend;
      out_uend <= sel_uend;
    end
  end

  `RNFP_ASSERT(a_idx_in_cmd, clk, rst, cur_valid |-> ({1'b0, idx} < tot), "position past command")
  `RNFP_ASSERT(a_unit_end_closes, clk, rst, (out_valid && out_uend) |-> out_pend, "unit end not at packet end")

endmodule

`default_nettype wire

/* rtl/core/rtp_nal_fragment_packetizer_core.sv */
// A byte goes through the command queue, command register and output register to rtp_out.
// One input word per cycle while the queue has room; one output word per cycle while ready.
// A byte that opens a packet expands to 13 to 16 words in the serializer;
// the 4-entry command queue absorbs that burst before input back-pressure.
// Reset is synchronous: counters, queue and output valid clear; max_payload 1400, step 3000.
// ----------------------------------------------------------------------------
// RTP NAL fragment packetizer core
// Front part classifies unit bytes into commands, a short queue decouples it
// from the serializer that emits RTP packet bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_nal_fragment_packetizer_core import rnfp_pkg::*; #(
  parameter int MAX_UNIT_BYTES    = 4194304,
  parameter int MAX_PAYLOAD_BYTES = 65532,
  parameter int CMD_DEPTH         = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  rnfp_in_if.sink                   nal_in,
  rnfp_out_if.source                rtp_out,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  logic push;
  logic pop;
  logic full;
  logic empty;
  cmd_t wr_cmd;
  cmd_t rd_cmd;

  // Front part: start code removal and packet decisions.
  rnfp_front #(
    .MAX_UNIT_BYTES    (MAX_UNIT_BYTES),
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .nal_in    (nal_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .full      (full),
    .push      (push),
    .cmd       (wr_cmd)
  );

  // Command queue between the two parts.
  rnfp_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .full   (full),
    .empty  (empty)
  );

  // Serializer: header and payload bytes out.
  rnfp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (rd_cmd),
    .empty   (empty),
    .pop     (pop),
    .rtp_out (rtp_out)
  );

endmodule

`default_nettype wire
